FILE: rtl/cnc_pkg.sv
// ----------------------------------------------------------------------------
// cnc_pkg: shared definitions for the channel name checker
// Grammar state codes, character constants, keyword tables and the
// per-byte grammar step record passed from the grammar logic to the top.
// ----------------------------------------------------------------------------
`default_nettype none

package cnc_pkg;

    localparam int unsigned MAX_NAME_LENGTH = 63;

    localparam int unsigned POS_W   = 7;   // position count, saturating
    localparam int unsigned STATE_W = 4;   // grammar state
    localparam int unsigned EXTLEN_W = 6;  // extension-name length
    localparam int unsigned PREFIX_W = 56; // seven prefix bytes

    localparam logic [POS_W-1:0]    POS_MAX    = {POS_W{1'b1}};
    localparam logic [POS_W-1:0]    POS_LIMIT  = POS_W'(MAX_NAME_LENGTH);
    localparam logic [EXTLEN_W-1:0] EXTLEN_MAX = {EXTLEN_W{1'b1}};

    localparam logic [PREFIX_W-1:0] PREFIX_RESET = 56'h706C696E74683A;

    localparam logic [1:0] LAYER_DATA = 2'd0;
    localparam logic [1:0] LAYER_SYS  = 2'd1;
    localparam logic [1:0] LAYER_EXT  = 2'd2;

    // Grammar state codes
    localparam logic [STATE_W-1:0] GS_PREFIX   = 4'd0;
    localparam logic [STATE_W-1:0] GS_KW_FIRST = 4'd1;
    localparam logic [STATE_W-1:0] GS_KW_DATA  = 4'd2;
    localparam logic [STATE_W-1:0] GS_KW_SYS   = 4'd3;
    localparam logic [STATE_W-1:0] GS_KW_EXT   = 4'd4;
    localparam logic [STATE_W-1:0] GS_D1_START = 4'd5;
    localparam logic [STATE_W-1:0] GS_D1_REST  = 4'd6;
    localparam logic [STATE_W-1:0] GS_D2_START = 4'd7;
    localparam logic [STATE_W-1:0] GS_D2_REST  = 4'd8;
    localparam logic [STATE_W-1:0] GS_Y_START  = 4'd9;
    localparam logic [STATE_W-1:0] GS_Y_REST   = 4'd10;
    localparam logic [STATE_W-1:0] GS_EN_START = 4'd11;
    localparam logic [STATE_W-1:0] GS_EN_REST  = 4'd12;
    localparam logic [STATE_W-1:0] GS_EI_START = 4'd13;
    localparam logic [STATE_W-1:0] GS_EI_REST  = 4'd14;
    localparam logic [STATE_W-1:0] GS_FAIL     = 4'd15;

    // Characters
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_E     = 8'h65;

    localparam logic [POS_W-1:0] KW_DATA_LEN = 7'd5;
    localparam logic [POS_W-1:0] KW_SYS_LEN  = 7'd7;
    localparam logic [POS_W-1:0] KW_EXT_LEN  = 7'd4;

    // Keyword tables, indexed by offset past the prefix
    function automatic logic [7:0] kw_data_char(input logic [2:0] k);
        logic [7:0] ch;
        unique case (k)
            3'd0:    ch = 8'h64; // d
            3'd1:    ch = 8'h61; // a
            3'd2:    ch = 8'h74; // t
            3'd3:    ch = 8'h61; // a
            3'd4:    ch = 8'h3A; // :
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] kw_sys_char(input logic [2:0] k);
        logic [7:0] ch;
        unique case (k)
            3'd0:    ch = 8'h73; // s
            3'd1:    ch = 8'h79; // y
            3'd2:    ch = 8'h73; // s
            3'd3:    ch = 8'h74; // t
            3'd4:    ch = 8'h65; // e
            3'd5:    ch = 8'h6D; // m
            3'd6:    ch = 8'h3A; // :
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] kw_ext_char(input logic [2:0] k);
        logic [7:0] ch;
        unique case (k)
            3'd0:    ch = 8'h65; // e
            3'd1:    ch = 8'h78; // x
            3'd2:    ch = 8'h74; // t
            3'd3:    ch = 8'h3A; // :
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // One grammar step: next state and the marks set on keyword completion
    typedef struct packed {
        logic [STATE_W-1:0] next_state;
        logic               set_layer_data;
        logic               set_layer_sys;
        logic               set_ext_prefix;
    } gram_step_t;

endpackage

`default_nettype wire

FILE: rtl/cnc_grammar.sv
// ----------------------------------------------------------------------------
// cnc_grammar: per-byte grammar transition
// Combinational next-state logic of the channel name grammar for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cnc_grammar (
    input  wire logic [cnc_pkg::STATE_W-1:0]  state,
    input  wire logic [7:0]                   char_code,
    input  wire logic [cnc_pkg::POS_W-1:0]    pos,
    input  wire logic [cnc_pkg::PREFIX_W-1:0] prefix_word,
    output cnc_pkg::gram_step_t               step
);

    logic [7:0]               prefix_byte;
    logic [cnc_pkg::POS_W-1:0] kw_pos;
    logic                      c_lower;
    logic                      c_digit;
    logic                      c_rest;

    assign c_lower = (char_code >= cnc_pkg::CH_A) && (char_code <= cnc_pkg::CH_Z);
    assign c_digit = (char_code >= cnc_pkg::CH_0) && (char_code <= cnc_pkg::CH_9);
    assign c_rest  = c_lower || c_digit || (char_code == cnc_pkg::CH_UNDER);
    assign kw_pos  = pos - 7'd7;

    // First prefix byte sits in the top eight bits
    always_comb
    begin
        unique case (pos[2:0])
            3'd0:    prefix_byte = prefix_word[55:48];
            3'd1:    prefix_byte = prefix_word[47:40];
            3'd2:    prefix_byte = prefix_word[39:32];
            3'd3:    prefix_byte = prefix_word[31:24];
            3'd4:    prefix_byte = prefix_word[23:16];
            3'd5:    prefix_byte = prefix_word[15:8];
            3'd6:    prefix_byte = prefix_word[7:0];
            default: prefix_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        step            = '0;
        step.next_state = cnc_pkg::GS_FAIL;
        unique case (state)
            cnc_pkg::GS_PREFIX:
            begin
                if (char_code == prefix_byte)
                    step.next_state = (pos == 7'd6) ? cnc_pkg::GS_KW_FIRST
                                                    : cnc_pkg::GS_PREFIX;
            end
            cnc_pkg::GS_KW_FIRST:
            begin
                priority if (char_code == cnc_pkg::CH_D) step.next_state = cnc_pkg::GS_KW_DATA;
                else if (char_code == cnc_pkg::CH_S)     step.next_state = cnc_pkg::GS_KW_SYS;
                else if (char_code == cnc_pkg::CH_E)     step.next_state = cnc_pkg::GS_KW_EXT;
                else                                     step.next_state = cnc_pkg::GS_FAIL;
            end
            cnc_pkg::GS_KW_DATA:
            begin
                if (kw_pos < cnc_pkg::KW_DATA_LEN &&
                    char_code == cnc_pkg::kw_data_char(kw_pos[2:0]))
                begin
                    if (kw_pos == cnc_pkg::KW_DATA_LEN - 7'd1)
                    begin
                        step.next_state     = cnc_pkg::GS_D1_START;
                        step.set_layer_data = 1'b1;
                    end
                    else
                        step.next_state = cnc_pkg::GS_KW_DATA;
                end
            end
            cnc_pkg::GS_KW_SYS:
            begin
                if (kw_pos < cnc_pkg::KW_SYS_LEN &&
                    char_code == cnc_pkg::kw_sys_char(kw_pos[2:0]))
                begin
                    if (kw_pos == cnc_pkg::KW_SYS_LEN - 7'd1)
                    begin
                        step.next_state    = cnc_pkg::GS_Y_START;
                        step.set_layer_sys = 1'b1;
                    end
                    else
                        step.next_state = cnc_pkg::GS_KW_SYS;
                end
            end
            cnc_pkg::GS_KW_EXT:
            begin
                if (kw_pos < cnc_pkg::KW_EXT_LEN &&
                    char_code == cnc_pkg::kw_ext_char(kw_pos[2:0]))
                begin
                    if (kw_pos == cnc_pkg::KW_EXT_LEN - 7'd1)
                    begin
                        step.next_state     = cnc_pkg::GS_EN_START;
                        step.set_ext_prefix = 1'b1;
                    end
                    else
                        step.next_state = cnc_pkg::GS_KW_EXT;
                end
            end
            cnc_pkg::GS_D1_START:
                if (c_lower) step.next_state = cnc_pkg::GS_D1_REST;
            cnc_pkg::GS_D1_REST:
            begin
                priority if (c_rest)             step.next_state = cnc_pkg::GS_D1_REST;
                else if (char_code == cnc_pkg::CH_DOT) step.next_state = cnc_pkg::GS_D2_START;
                else                             step.next_state = cnc_pkg::GS_FAIL;
            end
            cnc_pkg::GS_D2_START:
                if (c_lower) step.next_state = cnc_pkg::GS_D2_REST;
            cnc_pkg::GS_D2_REST:
                if (c_rest) step.next_state = cnc_pkg::GS_D2_REST;
            cnc_pkg::GS_Y_START:
                if (c_lower) step.next_state = cnc_pkg::GS_Y_REST;
            cnc_pkg::GS_Y_REST:
            begin
                priority if (c_rest)             step.next_state = cnc_pkg::GS_Y_REST;
                else if (char_code == cnc_pkg::CH_DOT) step.next_state = cnc_pkg::GS_Y_START;
                else                             step.next_state = cnc_pkg::GS_FAIL;
            end
            cnc_pkg::GS_EN_START:
                if (c_lower) step.next_state = cnc_pkg::GS_EN_REST;
            cnc_pkg::GS_EN_REST:
            begin
                priority if (c_lower || c_digit)   step.next_state = cnc_pkg::GS_EN_REST;
                else if (char_code == cnc_pkg::CH_COLON) step.next_state = cnc_pkg::GS_EI_START;
                else                               step.next_state = cnc_pkg::GS_FAIL;
            end
            cnc_pkg::GS_EI_START:
                if (c_lower) step.next_state = cnc_pkg::GS_EI_REST;
            cnc_pkg::GS_EI_REST:
            begin
                priority if (c_rest)             step.next_state = cnc_pkg::GS_EI_REST;
                else if (char_code == cnc_pkg::CH_DOT) step.next_state = cnc_pkg::GS_EI_START;
                else                             step.next_state = cnc_pkg::GS_FAIL;
            end
            default:
                step.next_state = cnc_pkg::GS_FAIL;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/channel_name_checker.sv
// ----------------------------------------------------------------------------
// channel_name_checker: streaming channel name grammar checker
// Checks a channel name, one byte per transaction, against a fixed grammar
// behind a programmable seven-byte prefix and reports one verdict per name.
// ----------------------------------------------------------------------------
//
//  channel   dir  signals                       payload
//  -------   ---  ----------------------------  ---------------------------------
//  s_*       in   s_tvalid s_tready s_tdata      tdata[7:0] char_code
//                 s_tlast                        tlast = last_char
//  m_*       out  m_tvalid m_tready m_tdata      tdata[0] name_valid, [2:1] layer_class,
//                                                [3] ext_name_found, [9:4] ext_name_length
//  cfg_*     in   cfg_valid cfg_ready cfg_data   cfg_data[55:0] prefix_word
//
// Flow: one byte per clock while s_tready is high; the verdict appears in the output register
// in the cycle after the last byte is accepted, set by the combinational grammar step.
// Reset: all name state returns to "expect prefix byte", the prefix returns to
// its default value, and the output register is emptied.
// Stalls: non-last bytes keep flowing while a verdict waits; a last byte is
// held off only while the output register is full and not being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module channel_name_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // last_char

    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata,   // [0] name_valid, [2:1] layer_class,
                                        // [3] ext_name_found, [9:4] ext_name_length

    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [55:0] cfg_data   // [55:0] prefix_word
);

    // Configuration
    logic [cnc_pkg::PREFIX_W-1:0] prefix_reg;

    // Per-name state
    logic [cnc_pkg::POS_W-1:0]    pos_reg,        pos_next;
    logic [cnc_pkg::STATE_W-1:0]  gstate_reg,     gstate_next;
    logic                         fail_reg,       fail_next;
    logic [1:0]                   layer_reg,      layer_next;
    logic [cnc_pkg::EXTLEN_W-1:0] extlen_reg,     extlen_next;
    logic                         colon_reg,      colon_next;
    logic                         extpre_reg,     extpre_next;

    // Output register
    logic                         out_valid_reg;
    logic                         valid_reg,      valid_next;
    logic [1:0]                   class_reg;
    logic                         found_reg,      found_next;
    logic [cnc_pkg::EXTLEN_W-1:0] outlen_reg,     outlen_next;

    cnc_pkg::gram_step_t          step;
    logic                         in_fire;
    logic                         last_fire;
    logic                         out_free;

    // Hold the last byte only while the verdict slot is busy
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = out_free || !s_tlast;
    assign in_fire   = s_tvalid && s_tready;
    assign last_fire = in_fire && s_tlast;
    assign cfg_ready = 1'b1;

    cnc_grammar u_grammar (
        .state       (gstate_reg),
        .char_code   (s_tdata),
        .pos         (pos_reg),
        .prefix_word (prefix_reg),
        .step        (step)
    );

    // Advance the name state for the accepted byte
    always_comb
    begin
        extlen_next = extlen_reg;
        colon_next  = colon_reg;
        // Count extension-name bytes up to the first colon, grammar or not
        if (extpre_reg && !colon_reg)
        begin
            if (s_tdata == cnc_pkg::CH_COLON)
                colon_next = 1'b1;
            else if (extlen_reg != cnc_pkg::EXTLEN_MAX)
                extlen_next = extlen_reg + 6'd1;
        end

        gstate_next = step.next_state;
        pos_next    = (pos_reg == cnc_pkg::POS_MAX) ? pos_reg : pos_reg + 7'd1;
        fail_next   = fail_reg || (pos_next > cnc_pkg::POS_LIMIT);

        layer_next = layer_reg;
        if (step.set_layer_data)
            layer_next = cnc_pkg::LAYER_DATA;
        else if (step.set_layer_sys)
            layer_next = cnc_pkg::LAYER_SYS;
        extpre_next = extpre_reg || step.set_ext_prefix;

        // Verdict built from the state after this byte
        valid_next  = !fail_next && ((gstate_next == cnc_pkg::GS_D2_REST) ||
                                     (gstate_next == cnc_pkg::GS_Y_REST)  ||
                                     (gstate_next == cnc_pkg::GS_EI_REST));
        found_next  = extpre_next && colon_next;
        outlen_next = found_next ? extlen_next : '0;
    end

    // Prefix register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prefix_reg <= cnc_pkg::PREFIX_RESET;
        else if (cfg_valid && cfg_ready)
            prefix_reg <= cfg_data;
    end

    // Name state: advance on each byte, drop back to start after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            gstate_reg <= cnc_pkg::GS_PREFIX;
            fail_reg   <= 1'b0;
            layer_reg  <= cnc_pkg::LAYER_EXT;
            extlen_reg <= '0;
            colon_reg  <= 1'b0;
            extpre_reg <= 1'b0;
        end
        else if (last_fire)
        begin
            pos_reg    <= '0;
            gstate_reg <= cnc_pkg::GS_PREFIX;
            fail_reg   <= 1'b0;
            layer_reg  <= cnc_pkg::LAYER_EXT;
            extlen_reg <= '0;
            colon_reg  <= 1'b0;
            extpre_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            pos_reg    <= pos_next;
            gstate_reg <= gstate_next;
            fail_reg   <= fail_next;
            layer_reg  <= layer_next;
            extlen_reg <= extlen_next;
            colon_reg  <= colon_next;
            extpre_reg <= extpre_next;
        end
    end

    // Output valid: load on the last byte, release when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (last_fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (last_fire)
        begin
            valid_reg  <= valid_next;
            class_reg  <= layer_next;
            found_reg  <= found_next;
            outlen_reg <= outlen_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, outlen_reg, found_reg, class_reg, valid_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A last byte always produces a verdict in the next cycle
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        last_fire |=> m_tvalid)
        else $error("last byte accepted without a verdict");

    // Name state is back at the start after a last byte
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        last_fire |=> (pos_reg == '0 && gstate_reg == cnc_pkg::GS_PREFIX))
        else $error("name state not cleared after last byte");

    // No extension length without a found extension name
    a_len_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[3]) |-> (m_tdata[9:4] == 6'd0))
        else $error("extension length reported without extension name");

    // A valid name outside data/system layers must be an extension with a colon
    a_valid_ext_found: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0] && m_tdata[2:1] == cnc_pkg::LAYER_EXT) |-> m_tdata[3])
        else $error("valid extension name without extension colon");

endmodule

`default_nettype wire

FILE: dv/channel_name_checker_mon.sv
// ----------------------------------------------------------------------------
// channel_name_checker_mon: verdict predictor and scoreboard
// Watches the byte, verdict and prefix channels of the channel name checker.
// It predicts one verdict per accepted last byte and compares every verdict
// transaction, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module channel_name_checker_mon
    import cnc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // last_char

    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // [0] name_valid, [2:1] layer_class,
                                        // [3] ext_name_found, [9:4] ext_name_length

    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [55:0] cfg_data,  // [55:0] prefix_word

    output int               fail_count,
    output int               pending_names
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [39:0] DATA_WORD = "data:";
    localparam logic [55:0] SYS_WORD  = "system:";
    localparam logic [31:0] EXT_WORD  = "ext:";

    typedef struct packed {
        logic                name_ok;
        logic [1:0]          layer;
        logic                ext_found;
        logic [EXTLEN_W-1:0] ext_len;
    } verdict_t;

    verdict_t verdict_q[$];

    logic [PREFIX_W-1:0] prefix_reg;
    logic [POS_W-1:0]    name_pos;
    logic [STATE_W-1:0]  gstate;
    logic                too_long;
    logic [1:0]          layer_so_far;
    logic [EXTLEN_W-1:0] ext_len_cnt;
    logic                ext_colon;
    logic                ext_seen;

    int errors  = 0;
    int waiting = 0;

    assign fail_count    = errors;
    assign pending_names = waiting;

    function automatic logic is_lower(input logic [7:0] c);
        return c >= CH_A && c <= CH_Z;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return is_lower(c) || is_digit(c) || c == CH_UNDER;
    endfunction

    task automatic clear_name();
        name_pos     = '0;
        gstate       = GS_PREFIX;
        too_long     = 1'b0;
        layer_so_far = LAYER_EXT;
        ext_len_cnt  = '0;
        ext_colon    = 1'b0;
        ext_seen     = 1'b0;
    endtask

    // Advance the grammar by one byte; on the last byte queue the verdict.
    task automatic take_name_byte(input logic [7:0] c, input logic is_last);
        logic [POS_W-1:0] pos;
        int               k;
        verdict_t         want;
        pos = name_pos;
        k   = int'(pos) - 7;

        // the extension length counts every byte up to the first colon,
        // whether or not the extension name is well formed
        if (ext_seen && !ext_colon) begin
            if (c == CH_COLON)
                ext_colon = 1'b1;
            else if (ext_len_cnt != EXTLEN_MAX)
                ext_len_cnt = ext_len_cnt + 1'b1;
        end

        case (gstate)
            GS_PREFIX:
                if (pos > 6 || c != prefix_reg[8*(6-int'(pos)) +: 8])
                    gstate = GS_FAIL;
                else if (pos == 6)
                    gstate = GS_KW_FIRST;
            GS_KW_FIRST:
                if (c == CH_D)      gstate = GS_KW_DATA;
                else if (c == CH_S) gstate = GS_KW_SYS;
                else if (c == CH_E) gstate = GS_KW_EXT;
                else                gstate = GS_FAIL;
            GS_KW_DATA:
                if (k < 0 || k >= 5)
                    gstate = GS_FAIL;
                else if (c != DATA_WORD[8*(4-k) +: 8])
                    gstate = GS_FAIL;
                else if (k == 4)
                begin
                    layer_so_far = LAYER_DATA;
                    gstate       = GS_D1_START;
                end
            GS_KW_SYS:
                if (k < 0 || k >= 7)
                    gstate = GS_FAIL;
                else if (c != SYS_WORD[8*(6-k) +: 8])
                    gstate = GS_FAIL;
                else if (k == 6)
                begin
                    layer_so_far = LAYER_SYS;
                    gstate       = GS_Y_START;
                end
            GS_KW_EXT:
                if (k < 0 || k >= 4)
                    gstate = GS_FAIL;
                else if (c != EXT_WORD[8*(3-k) +: 8])
                    gstate = GS_FAIL;
                else if (k == 3)
                begin
                    ext_seen = 1'b1;
                    gstate   = GS_EN_START;
                end
            GS_D1_START: gstate = is_lower(c) ? GS_D1_REST : GS_FAIL;
            GS_D1_REST:
                if (!is_ident_char(c))
                    gstate = (c == CH_DOT) ? GS_D2_START : GS_FAIL;
            GS_D2_START: gstate = is_lower(c) ? GS_D2_REST : GS_FAIL;
            GS_D2_REST:  gstate = is_ident_char(c) ? GS_D2_REST : GS_FAIL;
            GS_Y_START:  gstate = is_lower(c) ? GS_Y_REST : GS_FAIL;
            GS_Y_REST:
                if (!is_ident_char(c))
                    gstate = (c == CH_DOT) ? GS_Y_START : GS_FAIL;
            GS_EN_START: gstate = is_lower(c) ? GS_EN_REST : GS_FAIL;
            GS_EN_REST:
                if (!(is_lower(c) || is_digit(c)))
                    gstate = (c == CH_COLON) ? GS_EI_START : GS_FAIL;
            GS_EI_START: gstate = is_lower(c) ? GS_EI_REST : GS_FAIL;
            GS_EI_REST:
                if (!is_ident_char(c))
                    gstate = (c == CH_DOT) ? GS_EI_START : GS_FAIL;
            default:     gstate = GS_FAIL;
        endcase

        if (name_pos != POS_MAX)
            name_pos = name_pos + 1'b1;
        if (name_pos > POS_LIMIT)
            too_long = 1'b1;

        if (is_last)
        begin
            want.name_ok   = !too_long && (gstate == GS_D2_REST || gstate == GS_Y_REST ||
                                           gstate == GS_EI_REST);
            want.layer     = layer_so_far;
            want.ext_found = ext_seen && ext_colon;
            want.ext_len   = want.ext_found ? ext_len_cnt : '0;
            verdict_q.push_back(want);
            clear_name();
        end
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $error("%s: expected %0d, got %0d", fname, want, got);
        end
    endtask

    task automatic compare_verdict();
        verdict_t want;
        if (verdict_q.size() == 0)
        begin
            errors++;
            $error("verdict with no name pending: tdata=%h", m_tdata);
        end
        else
        begin
            want = verdict_q.pop_front();
            check_field("name_valid",      32'(want.name_ok),   32'(m_tdata[0]));
            check_field("layer_class",     32'(want.layer),     32'(m_tdata[2:1]));
            check_field("ext_name_found",  32'(want.ext_found), 32'(m_tdata[3]));
            check_field("ext_name_length", 32'(want.ext_len),   32'(m_tdata[9:4]));
            check_field("tdata padding",   32'd0,               32'(m_tdata[15:10]));
        end
    endtask

    // Verdicts leave no earlier than the cycle after their last byte, so compare before
    // taking in the byte of the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg = PREFIX_RESET;
            clear_name();
            verdict_q.delete();
            waiting = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                prefix_reg = cfg_data;
            if (m_tvalid && m_tready)
                compare_verdict();
            if (s_tvalid && s_tready)
                take_name_byte(s_tdata, s_tlast);
            waiting = verdict_q.size();
        end
    end

endmodule

FILE: dv/channel_name_checker_tb.sv
// ----------------------------------------------------------------------------
// channel_name_checker_tb: top-level testbench for the channel name checker
// Streams channel names byte by byte into the block, well formed and broken,
// under several prefixes, with bursty input and an irregular verdict sink.
// A separate monitor predicts and checks every verdict; this top only makes
// stimulus and gives the verdict of the run.
// ----------------------------------------------------------------------------
module channel_name_checker_tb
    import cnc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Well-formed name shapes the generator can build.
    typedef enum int { FORM_DATA, FORM_SYS, FORM_EXT } name_form_t;

    // Receiver behaviors; each runs for a random span of cycles, but the hold runs HOLD_CYCLES.
    typedef enum int { RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY, RX_HOLD } rx_mode_t;

    localparam int PHASE_BYTES = 300;   // random bytes per prefix setting
    localparam int HOLD_CYCLES = 400;   // length of the long receiver hold-off

    logic        clk = 1'b0;
    logic        rst_n;

    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] char_code
    logic        s_tlast;   // last_char

    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [0] name_valid, [2:1] layer_class,
                            // [3] ext_name_found, [9:4] ext_name_length

    logic        cfg_valid;
    logic        cfg_ready;
    logic [55:0] cfg_data;  // [55:0] prefix_word

    int mismatches;
    int pending_names;

    // Stimulus bookkeeping: our own view of the prefix, the name being
    // built, and the sender's burst pacing.
    logic [PREFIX_W-1:0] cur_prefix;
    logic [7:0]          name_q[$];
    int                  burst_left;
    int                  gap_max;
    int                  bytes_sent;

    always #1 clk = ~clk;

    channel_name_checker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    channel_name_checker_mon u_name_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (mismatches),
        .pending_names (pending_names)
    );

    // ------------------------------------------------------------------
    // Name construction: every helper appends to name_q
    // ------------------------------------------------------------------
    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            name_q.push_back(s[i]);
    endtask

    // Seven prefix bytes, first byte from the top of the register.
    task automatic push_prefix();
        for (int i = 6; i >= 0; i--)
            name_q.push_back(cur_prefix[8*i +: 8]);
    endtask

    function automatic logic [7:0] rand_lower();
        return 8'(CH_A + $urandom_range(0, 25));
    endfunction

    // Identifier of n bytes: a lower-case letter, then letters and digits,
    // plus underscores when allowed (extension names take none).
    task automatic push_ident(input int n, input logic allow_under);
        logic [7:0] pick;
        name_q.push_back(rand_lower());
        for (int i = 1; i < n; i++)
        begin
            case ($urandom_range(0, 5))
                0:       pick = 8'(CH_0 + $urandom_range(0, 9));
                1:       pick = allow_under ? CH_UNDER : rand_lower();
                default: pick = rand_lower();
            endcase
            name_q.push_back(pick);
        end
    endtask

    task automatic push_ident_list(input int count, input int maxlen);
        for (int i = 0; i < count; i++)
        begin
            if (i > 0)
                name_q.push_back(CH_DOT);
            push_ident($urandom_range(1, maxlen), 1'b1);
        end
    endtask

    task automatic build_good_name(input name_form_t form);
        push_prefix();
        case (form)
            FORM_DATA:
            begin
                // exactly two identifiers joined by one dot
                push_str("data:");
                push_ident_list(2, 8);
            end
            FORM_SYS:
            begin
                push_str("system:");
                push_ident_list($urandom_range(1, 4), 8);
            end
            default:
            begin
                push_str("ext:");
                push_ident($urandom_range(1, 8), 1'b0);
                name_q.push_back(CH_COLON);
                push_ident_list($urandom_range(1, 3), 6);
            end
        endcase
    endtask

    // Mostly well-formed names with random content, so the grammar gets
    // past the prefix and keyword; the rest is noise and broken names.
    task automatic build_random_name();
        int r;
        int at;
        r = $urandom_range(0, 99);
        if (r < 55)
            build_good_name(name_form_t'($urandom_range(0, 2)));
        else if (r < 60)
        begin
            // extension name with no colon after it
            push_prefix();
            push_str("ext:");
            push_ident($urandom_range(1, 10), 1'b0);
        end
        else if (r < 63)
        begin
            // near or over the length limit, sometimes past the position saturation
            push_prefix();
            push_str("system:");
            push_ident($urandom_range(40, 125), 1'b1);
        end
        else if (r < 70)
        begin
            repeat ($urandom_range(1, 20))
                name_q.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 75)
        begin
            // one flipped bit inside the prefix
            build_good_name(FORM_DATA);
            at = $urandom_range(0, 6);
            name_q[at] = name_q[at] ^ (8'h01 << $urandom_range(0, 7));
        end
        else
        begin
            // break a good name at a random place
            build_good_name(name_form_t'($urandom_range(0, 2)));
            at = $urandom_range(0, name_q.size() - 1);
            case ($urandom_range(0, 5))
                0:       name_q = name_q[0:at];
                1:       name_q.insert(at, CH_DOT);
                2:       name_q[at] = CH_COLON;
                3:       name_q[at] = CH_UNDER;
                4:       name_q[at] = 8'h41;    // upper-case letter
                default: name_q[at] = 8'($urandom_range(0, 255));
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one byte and hold it until the handshake. Drop valid for a
    // random gap at the start of each burst.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent++;
    endtask

    // Stream the built name, flag its last byte, and empty the buffer.
    task automatic send_name();
        for (int i = 0; i < name_q.size(); i++)
            send_byte(name_q[i], i == name_q.size() - 1);
        name_q.delete();
    endtask

    // Drop valid and hold until every predicted verdict has come back.
    // Sample the monitor's count on the falling edge, away from updates.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_names != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_prefix(input logic [PREFIX_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid  <= 1'b0;
        cur_prefix = value;
    endtask

    // ------------------------------------------------------------------
    // Directed names under the reset prefix
    // ------------------------------------------------------------------
    task automatic run_directed();
        push_prefix(); push_str("data:ab.c_9");     send_name();
        push_prefix(); push_str("system:x");        send_name();
        push_prefix(); push_str("system:a1.b_.zz"); send_name();
        push_prefix(); push_str("ext:abc9:id.x");   send_name();
        // extension name with no colon: not found, length reported as zero
        push_prefix(); push_str("ext:abc");         send_name();
        // bad extension name still counts its length up to the colon
        push_prefix(); push_str("ext:a_b:c");       send_name();
        push_prefix(); push_str("ext::a");          send_name();
        push_prefix(); push_str("ext:9a:b");        send_name();
        // data takes exactly two identifiers
        push_prefix(); push_str("data:a.b.c");      send_name();
        push_prefix(); push_str("data:a.");         send_name();
        push_prefix(); push_str("system:9a");       send_name();
        push_prefix(); push_str("data:Ab.c");       send_name();
        push_prefix(); push_str("sys");             send_name();
        push_prefix();                              send_name();
        // byte extremes and a one-byte name
        name_q.push_back(8'hFF); name_q.push_back(8'h00); send_name();
        name_q.push_back(cur_prefix[55:48]);              send_name();
        push_prefix(); name_q[3] = name_q[3] ^ 8'h10; push_str("data:a.b"); send_name();
        // exactly at the length limit, one past it, and past saturation
        push_prefix(); push_str("system:"); push_ident(49, 1'b1);  send_name();
        push_prefix(); push_str("system:"); push_ident(50, 1'b1);  send_name();
        push_prefix(); push_str("system:"); push_ident(126, 1'b1); send_name();
        // extension length saturates while the name is too long
        push_prefix(); push_str("ext:"); push_ident(70, 1'b0); push_str(":a"); send_name();
    endtask

    // ------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [PREFIX_W-1:0] next_prefix;
        int                  phase_end;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        cur_prefix = PREFIX_RESET;
        burst_left = 0;
        gap_max    = 4;
        bytes_sent = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Each phase: drain, let the last byte settle, write a new prefix,
        // then stream random names. Zeros and ones cover the extremes.
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_drained();
            repeat (4) @(posedge clk);
            case (ph)
                0:       next_prefix = '0;
                1:       next_prefix = '1;
                2:       next_prefix = PREFIX_W'({$urandom, $urandom});
                default: next_prefix = PREFIX_RESET;
            endcase
            write_prefix(next_prefix);
            // one phase runs with no input gaps at all
            gap_max   = (ph == 1) ? 0 : $urandom_range(2, 8);
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
            begin
                build_random_name();
                send_name();
                if ($urandom_range(0, 15) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("channel_name_checker_tb OK");
        else
            $display("channel_name_checker_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Verdict sink: random stall patterns, with a long hold-off now and
    // then so the output register fills and the last byte backs up.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        rx_mode_t mode;
        int       span;
        int       seg;
        m_tready = 1'b0;
        seg      = 0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (seg % 16 == 3)
            begin
                mode = RX_HOLD;
                span = HOLD_CYCLES;
            end
            else
            begin
                mode = rx_mode_t'($urandom_range(0, 3));
                span = $urandom_range(20, 200);
            end
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
                    RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                    default:   m_tready <= 1'b0;
                endcase
            end
            seg++;
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin : watchdog
        #(2_000_000);
        $display("channel_name_checker_tb NOT OK");
        $finish;
    end

endmodule

FILE: files.f
rtl/cnc_pkg.sv
rtl/cnc_grammar.sv
rtl/channel_name_checker.sv
dv/channel_name_checker_mon.sv
dv/channel_name_checker_tb.sv
